FILE: rtl/probe_latency_tracker_defines.svh
// Assertion macros used by the checker file of the probe latency tracker.
`ifndef PROBE_LATENCY_TRACKER_DEFINES_SVH
`define PROBE_LATENCY_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/plt_pkg.sv
// Shared types and constants of the probe latency tracker.
`timescale 1ns / 1ps

package plt_pkg;

  // Table size default and field widths.
  localparam int unsigned SLOTS_DEF  = 65536;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned MSG_W      = 8;
  localparam int unsigned DELAY_W    = 20;
  localparam int unsigned EXP_W      = 5;
  localparam int unsigned RATE_W     = 17;
  localparam int unsigned SPR_W      = 8;
  localparam int unsigned INTERVAL_W = 20;
  localparam int unsigned PHASE_W    = 28;

  // Protocol constants.
  localparam int unsigned US_PER_SEC    = 1000000;
  localparam int unsigned MIN_FRAME_LEN = 70;
  localparam int unsigned TYPE_REQUEST  = 16;
  localparam int unsigned TYPE_REPLY    = 17;
  localparam int unsigned MAX_EXP       = 31;

  // Request kinds on the input channel.
  localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RATE    = 2'd2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_CEILING  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SECONDS = 4'd1;
  localparam logic [RATE_W-1:0]    RATE_CEILING_RST  = 17'd1024;
  localparam logic [SPR_W-1:0]     SPR_RST           = 8'd5;

  // Queue between the classifier and the execution unit.
  localparam int unsigned QDEPTH = 2;

  // Operation decided by the classifier.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_SEND    = 3'd1,
    OP_REQUEST = 3'd2,
    OP_REPLY   = 3'd3,
    OP_RATE    = 3'd4
  } op_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] time_us;
    logic [TAG_W-1:0]  tag;
  } item_t;

endpackage

FILE: rtl/plt_front.sv
// Classifier: turns an input transfer into a queued operation.
`timescale 1ns / 1ps

module plt_front #(
  parameter int unsigned SLOTS = plt_pkg::SLOTS_DEF
) (
  input  logic [plt_pkg::KIND_W-1:0] in_req_type,
  input  logic [plt_pkg::TIME_W-1:0] in_event_time_us,
  input  logic                       in_from_control_channel,
  input  logic [plt_pkg::LEN_W-1:0]  in_frame_length,
  input  logic [plt_pkg::MSG_W-1:0]  in_msg_type,
  input  logic [plt_pkg::TAG_W-1:0]  in_tag_index,
  output plt_pkg::item_t             item
);
  import plt_pkg::*;

  logic frame_ok;

  // A capture counts only from the control channel, long enough and naming a real slot.
  assign frame_ok = in_from_control_channel
                 && (in_frame_length >= LEN_W'(MIN_FRAME_LEN))
                 && ({1'b0, in_tag_index} < (TAG_W + 1)'(SLOTS));

  always_comb begin
    item.op      = OP_NONE;
    item.time_us = in_event_time_us;
    item.tag     = '0;
    case (in_req_type)
      KIND_SEND: begin
        item.op = OP_SEND;
      end
      KIND_CAPTURE: begin
        // Ignored captures still report the slot they named.
        item.tag = in_tag_index;
        if (frame_ok && in_msg_type == MSG_W'(TYPE_REQUEST)) begin
          item.op = OP_REQUEST;
        end else if (frame_ok && in_msg_type == MSG_W'(TYPE_REPLY)) begin
          item.op = OP_REPLY;
        end
      end
      KIND_RATE: begin
        item.op = OP_RATE;
      end
      default: begin
        item.op = OP_NONE;
      end
    endcase
  end

endmodule

FILE: rtl/plt_queue.sv
// Short queue of classified items between the classifier and the execution unit.
`timescale 1ns / 1ps

module plt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  plt_pkg::item_t push_item,
  input  logic           pop,
  output plt_pkg::item_t pop_item,
  output logic           not_empty,
  output logic           full
);
  import plt_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  item_t              entry_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [PTR_W:0]     cnt_r;
  logic [PTR_W:0]     cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (PTR_W + 1)'(QDEPTH));
  assign pop_item  = entry_r[rd_ptr_r];

  // Pointer and occupancy update; the depth is a power of two so pointers wrap.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/plt_back.sv
// Execution unit: probe table, rate schedule and running totals.
`timescale 1ns / 1ps

module plt_back #(
  parameter int unsigned SLOTS = plt_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  plt_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          clearing,
  input  logic [plt_pkg::RATE_W-1:0]    rate_ceiling,
  input  logic [plt_pkg::SPR_W-1:0]     phase_seconds,
  output logic                          out_valid,
  output logic [plt_pkg::TAG_W-1:0]     out_slot_used,
  output logic                          out_overwrote_unreturned,
  output logic                          out_delay_valid,
  output logic [plt_pkg::DELAY_W-1:0]   out_delay_us,
  output logic [plt_pkg::TIME_W-1:0]    out_next_time_us,
  output logic                          out_next_is_rate_change,
  output logic                          out_test_done,
  output logic [plt_pkg::EXP_W-1:0]     out_rate_exponent,
  output logic [plt_pkg::TIME_W-1:0]    out_sent_total,
  output logic [plt_pkg::TIME_W-1:0]    out_received_total,
  output logic [plt_pkg::TIME_W-1:0]    out_delay_sum
);
  import plt_pkg::*;

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned ENTRY_W = TIME_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [SLOT_W-1:0]       clr_addr_r;

  // Table: pending mark on top of the stored request time.
  logic [ENTRY_W-1:0]      mem_r [SLOTS];
  logic [ENTRY_W-1:0]      rdata_r;
  logic                    mem_re;
  logic [SLOT_W-1:0]       mem_raddr;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]      mem_wdata;

  // Item in flight and values prepared while the table is read.
  item_t                   item_r;
  logic [TIME_W-1:0]       nxt_r;
  logic [TIME_W-1:0]       nxt_rc_r;
  logic [PHASE_W-1:0]      phase_len_r;

  // Schedule and totals.
  logic [EXP_W-1:0]        exp_r;
  logic [EXP_W-1:0]        exp_nxt;
  logic [INTERVAL_W-1:0]   interval_r;
  logic [INTERVAL_W-1:0]   interval_nxt;
  logic [INTERVAL_W:0]     interval_rc_r;
  logic [INTERVAL_W:0]     interval_rc_nxt;
  logic [SLOT_W-1:0]       next_slot_r;
  logic [SLOT_W-1:0]       next_slot_nxt;
  logic [TIME_W-1:0]       phase_end_r;
  logic [TIME_W-1:0]       phase_end_nxt;
  logic [TIME_W-1:0]       send_cnt_r;
  logic [TIME_W-1:0]       send_cnt_nxt;
  logic [TIME_W-1:0]       reply_cnt_r;
  logic [TIME_W-1:0]       reply_cnt_nxt;
  logic [TIME_W-1:0]       delay_tot_r;
  logic [TIME_W-1:0]       delay_tot_nxt;

  // Result fields of the executing item.
  logic [TAG_W-1:0]        slot_o;
  logic                    over_o;
  logic                    dv_o;
  logic [DELAY_W-1:0]      dus_o;
  logic [TIME_W-1:0]       next_time_o;
  logic                    rc_o;
  logic                    done_o;

  // Execution helpers.
  logic                    pend;
  logic [TIME_W-1:0]       sent;
  logic [TIME_W:0]         diff;
  logic                    reply_ok;
  logic [EXP_W-1:0]        exp_up;
  logic [RATE_W+15:0]      rate_new;
  logic                    rate_over;

  assign clearing = (state_r == S_CLEAR);

  assign pend      = rdata_r[TIME_W];
  assign sent      = rdata_r[TIME_W-1:0];
  assign diff      = {1'b0, item_r.time_us} - {1'b0, sent};
  assign reply_ok  = !diff[TIME_W] && (diff[TIME_W-1:0] < TIME_W'(US_PER_SEC));
  assign exp_up    = (exp_r == EXP_W'(MAX_EXP)) ? exp_r : exp_r + 1'b1;
  assign rate_new  = (RATE_W + 16)'(1) << exp_up;
  assign rate_over = rate_new > (RATE_W + 16)'(rate_ceiling);

  // Sequencer, table port selection and execution of one operation.
  always_comb begin
    state_nxt       = state_r;
    q_pop           = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = (q_item.op == OP_SEND) ? next_slot_r : q_item.tag[SLOT_W-1:0];
    mem_we          = 1'b0;
    mem_waddr       = clr_addr_r;
    mem_wdata       = '0;
    exp_nxt         = exp_r;
    interval_nxt    = interval_r;
    interval_rc_nxt = interval_rc_r;
    next_slot_nxt   = next_slot_r;
    phase_end_nxt   = phase_end_r;
    send_cnt_nxt    = send_cnt_r;
    reply_cnt_nxt   = reply_cnt_r;
    delay_tot_nxt   = delay_tot_r;
    slot_o          = '0;
    over_o          = 1'b0;
    dv_o            = 1'b0;
    dus_o           = '0;
    next_time_o     = '0;
    rc_o            = 1'b0;
    done_o          = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          mem_re    = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (item_r.op)
          OP_SEND: begin
            slot_o        = TAG_W'(next_slot_r);
            over_o        = pend;
            mem_we        = 1'b1;
            mem_waddr     = next_slot_r;
            mem_wdata     = {1'b1, {TIME_W{1'b0}}};
            next_slot_nxt = (next_slot_r == SLOT_W'(SLOTS - 1)) ? '0 : next_slot_r + 1'b1;
            send_cnt_nxt  = send_cnt_r + 1'b1;
            // Past the phase end the next event is a rate change a second later.
            if (phase_end_r > nxt_r) begin
              next_time_o = nxt_r;
            end else begin
              next_time_o = nxt_rc_r;
              rc_o        = 1'b1;
            end
          end
          OP_REQUEST: begin
            slot_o    = item_r.tag;
            mem_we    = 1'b1;
            mem_waddr = item_r.tag[SLOT_W-1:0];
            mem_wdata = {pend, item_r.time_us};
          end
          OP_REPLY: begin
            slot_o = item_r.tag;
            if (reply_ok) begin
              mem_we        = 1'b1;
              mem_waddr     = item_r.tag[SLOT_W-1:0];
              mem_wdata     = {1'b0, sent};
              dv_o          = 1'b1;
              dus_o         = diff[DELAY_W-1:0];
              reply_cnt_nxt = reply_cnt_r + 1'b1;
              delay_tot_nxt = delay_tot_r + TIME_W'(diff[DELAY_W-1:0]);
            end
          end
          OP_RATE: begin
            exp_nxt         = exp_up;
            next_slot_nxt   = '0;
            interval_nxt    = INTERVAL_W'(32'(US_PER_SEC) >> exp_up);
            interval_rc_nxt = (INTERVAL_W + 1)'(interval_nxt)
                            + (INTERVAL_W + 1)'(US_PER_SEC);
            if (rate_over) begin
              done_o = 1'b1;
            end else begin
              phase_end_nxt = item_r.time_us + TIME_W'(phase_len_r);
              next_time_o   = item_r.time_us;
            end
          end
          default: begin
            slot_o = item_r.tag;
          end
        endcase
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      exp_r         <= '0;
      interval_r    <= INTERVAL_W'(US_PER_SEC);
      interval_rc_r <= (INTERVAL_W + 1)'(2 * US_PER_SEC);
      next_slot_r   <= '0;
      phase_end_r   <= '0;
      send_cnt_r    <= '0;
      reply_cnt_r   <= '0;
      delay_tot_r   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      exp_r         <= exp_nxt;
      interval_r    <= interval_nxt;
      interval_rc_r <= interval_rc_nxt;
      next_slot_r   <= next_slot_nxt;
      phase_end_r   <= phase_end_nxt;
      send_cnt_r    <= send_cnt_nxt;
      reply_cnt_r   <= reply_cnt_nxt;
      delay_tot_r   <= delay_tot_nxt;
      out_valid     <= (state_r == S_EXEC);
    end
  end

  // Item capture and the sums that only need the item and the schedule.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r      <= q_item;
      nxt_r       <= q_item.time_us + TIME_W'(interval_r);
      nxt_rc_r    <= q_item.time_us + TIME_W'(interval_rc_r);
      phase_len_r <= PHASE_W'(32'(phase_seconds) * 32'(US_PER_SEC));
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    out_slot_used            <= slot_o;
    out_overwrote_unreturned <= over_o;
    out_delay_valid          <= dv_o;
    out_delay_us             <= dus_o;
    out_next_time_us         <= next_time_o;
    out_next_is_rate_change  <= rc_o;
    out_test_done            <= done_o;
    out_rate_exponent        <= exp_nxt;
    out_sent_total           <= send_cnt_nxt;
    out_received_total       <= reply_cnt_nxt;
    out_delay_sum            <= delay_tot_nxt;
  end

  // Table write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  // Table read port.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem_r[mem_raddr];
    end
  end

endmodule

FILE: rtl/probe_latency_tracker.sv
// Top level of the probe latency tracker.
`timescale 1ns / 1ps

// Probe latency tracker.
// Input channel: an item is taken at a rising edge with start high and busy low.
// in_req_type selects a send tick, a captured frame or a rate change.
// Result channel: exactly one result per item, shown for one cycle with out_valid
// high; the receiver takes it in that cycle and cannot hold it off.
// Configuration: cfg_valid/cfg_ready write channel, index 0 is the rate ceiling
// and index 1 is the phase length in seconds; cfg_ready is always high. Write
// only while idle.
// Result path: an accepted item is queued, its table slot is read in S_IDLE,
// the update runs in S_EXEC and the result is registered; it waits longer while
// an earlier item is still queued or executing. Items execute one at a time, each
// as a read-modify-write of the probe table that ends before the next read.
// A two-entry queue sits between the classifier and the execution unit, so
// items may arrive back to back; busy rises while the queue is full.
// Reset: after rst_n is released the probe table is cleared one slot per cycle,
// all SLOTS slots (65536 by default), with busy high; configuration writes
// are taken during that pass. Configuration returns to 1024 and 5.
module probe_latency_tracker #(
  parameter int unsigned SLOTS = plt_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [plt_pkg::KIND_W-1:0]      in_req_type,
  input  logic [plt_pkg::TIME_W-1:0]      in_event_time_us,
  input  logic                            in_from_control_channel,
  input  logic [plt_pkg::LEN_W-1:0]       in_frame_length,
  input  logic [plt_pkg::MSG_W-1:0]       in_msg_type,
  input  logic [plt_pkg::TAG_W-1:0]       in_tag_index,
  output logic                            out_valid,
  output logic [plt_pkg::TAG_W-1:0]       out_slot_used,
  output logic                            out_overwrote_unreturned,
  output logic                            out_delay_valid,
  output logic [plt_pkg::DELAY_W-1:0]     out_delay_us,
  output logic [plt_pkg::TIME_W-1:0]      out_next_time_us,
  output logic                            out_next_is_rate_change,
  output logic                            out_test_done,
  output logic [plt_pkg::EXP_W-1:0]       out_rate_exponent,
  output logic [plt_pkg::TIME_W-1:0]      out_sent_total,
  output logic [plt_pkg::TIME_W-1:0]      out_received_total,
  output logic [plt_pkg::TIME_W-1:0]      out_delay_sum,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [plt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import plt_pkg::*;

  logic [RATE_W-1:0] rate_ceiling_r;
  logic [SPR_W-1:0]  spr_r;
  item_t             front_item;
  item_t             q_item;
  logic              push;
  logic              q_pop;
  logic              q_not_empty;
  logic              q_full;
  logic              clearing;

  assign cfg_ready = 1'b1;
  assign busy      = clearing || q_full;
  assign push      = start && !busy;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_ceiling_r <= RATE_CEILING_RST;
      spr_r          <= SPR_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_RATE_CEILING) begin
        rate_ceiling_r <= cfg_data[RATE_W-1:0];
      end else if (cfg_index == CFG_PHASE_SECONDS) begin
        spr_r <= cfg_data[SPR_W-1:0];
      end
    end
  end

  plt_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .in_req_type             (in_req_type),
    .in_event_time_us        (in_event_time_us),
    .in_from_control_channel (in_from_control_channel),
    .in_frame_length         (in_frame_length),
    .in_msg_type             (in_msg_type),
    .in_tag_index            (in_tag_index),
    .item                    (front_item)
  );

  plt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  plt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_not_empty              (q_not_empty),
    .q_item                   (q_item),
    .q_pop                    (q_pop),
    .clearing                 (clearing),
    .rate_ceiling             (rate_ceiling_r),
    .phase_seconds            (spr_r),
    .out_valid                (out_valid),
    .out_slot_used            (out_slot_used),
    .out_overwrote_unreturned (out_overwrote_unreturned),
    .out_delay_valid          (out_delay_valid),
    .out_delay_us             (out_delay_us),
    .out_next_time_us         (out_next_time_us),
    .out_next_is_rate_change  (out_next_is_rate_change),
    .out_test_done            (out_test_done),
    .out_rate_exponent        (out_rate_exponent),
    .out_sent_total           (out_sent_total),
    .out_received_total       (out_received_total),
    .out_delay_sum            (out_delay_sum)
  );

endmodule

FILE: rtl/plt_checker.sv
// Port-level checks of the probe latency tracker and their bind.
`timescale 1ns / 1ps
`include "probe_latency_tracker_defines.svh"

module plt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic        out_delay_valid,
  input logic [19:0] out_delay_us,
  input logic [63:0] out_received_total,
  input logic [63:0] out_next_time_us,
  input logic        out_next_is_rate_change,
  input logic        out_test_done
);

  // The table clearing pass holds the input side off right after reset.
  `PLT_ASSERT_IMPL(a_clear_after_reset, clk, rst_n, !$past(rst_n), busy, "busy low right after reset")

  // Each item spends an S_IDLE read state and an S_EXEC update state, so strobes never touch.
  `PLT_ASSERT_NEXT(a_strobe_spacing, clk, rst_n, out_valid, !out_valid, "results in adjacent cycles")

  // An accepted delay lies within one second and has been counted.
  `PLT_ASSERT_IMPL(a_delay_counted, clk, rst_n, out_valid && out_delay_valid, (out_delay_us < 20'd1000000) && (out_received_total != 64'd0), "accepted delay out of range or uncounted")

  // A finished experiment schedules nothing further.
  `PLT_ASSERT_IMPL(a_done_no_next, clk, rst_n, out_valid && out_test_done, (out_next_time_us == 64'd0) && !out_next_is_rate_change, "next event after test done")

endmodule

bind probe_latency_tracker plt_checker u_plt_checker (.*);
